/* rtl/crpd_pkg.sv */
`timescale 1ns / 1ps
// Package for the connection-rate probe detector: beat types of the event and result
// channels, the configuration bundle and the layout of one table entry. No dependencies.
package crpd_pkg;

	typedef struct packed {
		logic [31:0] source_addr;
		logic [31:0] now_sec;
	} conn_t;

	typedef struct packed {
		logic        probe_alert;
		logic        matched;
		logic        evicted;
		logic [5:0]  entry_slot;
		logic [7:0]  count_after;
		logic        ignored;
	} result_t;

	typedef struct packed {
		logic        monitor_enable;
		logic [15:0] window_seconds;
		logic [7:0]  probe_threshold;
	} cfg_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] last_seen;
		logic [7:0]  count;
	} entry_t;

endpackage

/* rtl/connection_rate_probe_detector.sv */
`timescale 1ns / 1ps
// Top level of the connection-rate probe detector: APB register block and table engine.
// Depends on crpd_pkg and crpd_engine.

// An event is taken when start is high and busy is low. With monitoring enabled the engine
// reads every filled table entry once from the entry memory, one per cycle, and then writes
// the updated entry back, so the result strobe is registered at the end of the WRITE state
// that follows the SCAN state. With monitoring disabled the result comes in the cycle after
// acceptance. Each result is on the result port for a single cycle marked by result_valid
// and must be taken then; busy is already low in that cycle, so the next event may be
// accepted alongside it. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
module connection_rate_probe_detector #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	input  crpd_pkg::conn_t   conn,
	output logic              busy,
	output logic              result_valid,
	output crpd_pkg::result_t result
);

	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_WINDOW    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	crpd_pkg::cfg_t cfg_q;
	logic           cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.monitor_enable  <= 1'b1;
			cfg_q.window_seconds  <= 16'd60;
			cfg_q.probe_threshold <= 8'd25;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_ENABLE:    cfg_q.monitor_enable  <= pwdata[0];
				REG_WINDOW:    cfg_q.window_seconds  <= pwdata[15:0];
				REG_THRESHOLD: cfg_q.probe_threshold <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ENABLE:    prdata = {31'd0, cfg_q.monitor_enable};
			REG_WINDOW:    prdata = {16'd0, cfg_q.window_seconds};
			REG_THRESHOLD: prdata = {24'd0, cfg_q.probe_threshold};
			default:       prdata = 32'd0;
		endcase
	end

	crpd_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.conn         (conn),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef ASSERT_OFF
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || result_valid))
		else $error("accepted beat neither started a scan nor produced a result");

	a_match_xor_evict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.matched && result.evicted))
		else $error("result both matched and evicted");

	a_alert_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.probe_alert) |-> (result.matched && result.count_after == 8'd0))
		else $error("alert without a matched entry or with a non-zero count");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.ignored) |->
			(!result.probe_alert && !result.matched && result.count_after == 8'd0))
		else $error("ignored beat carried table results");
`endif

endmodule

/* rtl/crpd_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
module crpd_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/crpd_engine.sv */
`timescale 1ns / 1ps
// Table engine: scans the entry memory for a match and the oldest entry, then writes back.
// Depends on crpd_pkg and crpd_ram.
module crpd_engine #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crpd_pkg::cfg_t   cfg,
	input  logic             start,
	input  crpd_pkg::conn_t  conn,
	output logic             busy,
	output logic             result_valid,
	output crpd_pkg::result_t result
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int EXT_W  = (IDX_W > 6) ? IDX_W : 6;
	localparam int ENT_W  = $bits(crpd_pkg::entry_t);
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] used_q;
	logic [31:0]      addr_q;
	logic [31:0]      now_q;
	logic [31:0]      cutoff_q;
	logic [7:0]       thr_q;
	logic             valid_s1;
	logic [IDX_W-1:0] index_s1;
	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [31:0]      match_ts_q;
	logic [7:0]       match_cnt_q;
	logic [IDX_W-1:0] oldest_idx_q;
	logic [31:0]      oldest_ts_q;
	crpd_pkg::result_t result_q;
	logic             result_valid_q;

	logic             issue;
	logic [ENT_W-1:0] rd_data;
	crpd_pkg::entry_t rd_entry;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	crpd_pkg::entry_t wr_entry;
	crpd_pkg::result_t wr_result;
	logic             table_full;
	logic [7:0]       cnt_base;
	logic [7:0]       cnt_inc;
	logic             hit_alert;
	logic [EXT_W-1:0] slot_ext;
	logic [31:0]      cutoff_in;

	assign issue    = (state_q == ST_SCAN) && (idx_q < used_q);
	assign rd_entry = rd_data;
	assign cutoff_in = (conn.now_sec >= 32'(cfg.window_seconds)) ?
		conn.now_sec - 32'(cfg.window_seconds) : 32'd0;

	crpd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		table_full = (used_q == CNT_W'(TABLE_ENTRIES));
		cnt_base   = (match_ts_q < cutoff_q) ? 8'd0 : match_cnt_q;
		cnt_inc    = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 8'd1;
		hit_alert  = (cnt_inc >= thr_q);
		wr_en      = (state_q == ST_WRITE);
		if (found_q) begin
			wr_idx = match_idx_q;
		end else if (table_full) begin
			wr_idx = oldest_idx_q;
		end else begin
			wr_idx = used_q[IDX_W-1:0];
		end
		slot_ext              = EXT_W'(wr_idx);
		wr_entry.addr         = addr_q;
		wr_entry.last_seen    = now_q;
		wr_entry.count        = found_q ? (hit_alert ? 8'd0 : cnt_inc) : 8'd1;
		wr_result.probe_alert = found_q && hit_alert;
		wr_result.matched     = found_q;
		wr_result.evicted     = !found_q && table_full;
		wr_result.entry_slot  = slot_ext[5:0];
		wr_result.count_after = wr_entry.count;
		wr_result.ignored     = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			used_q         <= '0;
			idx_q          <= '0;
			valid_s1       <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			valid_s1       <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cfg.monitor_enable) begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							result_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_WRITE;
					end
					if (valid_s1 && !found_q && rd_entry.addr == addr_q) begin
						found_q <= 1'b1;
					end
				end
				ST_WRITE: begin
					if (!found_q && !table_full) begin
						used_q <= used_q + CNT_W'(1);
					end
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		index_s1 <= idx_q[IDX_W-1:0];
		if (state_q == ST_IDLE && start) begin
			addr_q   <= conn.source_addr;
			now_q    <= conn.now_sec;
			cutoff_q <= cutoff_in;
			thr_q    <= cfg.probe_threshold;
			result_q <= '{probe_alert: 1'b0, matched: 1'b0, evicted: 1'b0,
				entry_slot: 6'd0, count_after: 8'd0, ignored: 1'b1};
		end
		if (state_q == ST_SCAN && valid_s1) begin
			if (!found_q && rd_entry.addr == addr_q) begin
				match_idx_q <= index_s1;
				match_ts_q  <= rd_entry.last_seen;
				match_cnt_q <= rd_entry.count;
			end
			if (index_s1 == '0 || rd_entry.last_seen < oldest_ts_q) begin
				oldest_idx_q <= index_s1;
				oldest_ts_q  <= rd_entry.last_seen;
			end
		end
		if (state_q == ST_WRITE) begin
			result_q <= wr_result;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
